@@ src/graph_matrix_dfs_engine_assert.svh @@
// assertion helpers for the graph engine
`ifndef GRAPH_MATRIX_DFS_ENGINE_ASSERT_SVH
`define GRAPH_MATRIX_DFS_ENGINE_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define GMD_ASSERT_NOW(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// condition must hold in the cycle after the trigger
`define GMD_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

@@ src/gmd_pkg.sv @@
`timescale 1ns / 1ps

package gmd_pkg;

    // payload field widths
    localparam int REQ_TYPE_W    = 3;
    localparam int NODE_W        = 4;
    localparam int EDGE_WEIGHT_W = 16;
    localparam int VALUE_W       = 5;
    localparam int NUM_NODES_W   = 5;

    // defaults for the top level parameters
    localparam int DEF_NODES       = 16;
    localparam int DEF_WEIGHT_BITS = 16;

    // num_nodes after reset
    localparam logic [NUM_NODES_W-1:0] NUM_NODES_RESET = 5'd16;

    // at most this many traversal results per item
    localparam int OUT_CAP = 16;
    localparam int CNT_W   = $clog2(OUT_CAP + 1);

    // request codes
    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_ADD    = 3'd0,
        REQ_EDGE   = 3'd1,
        REQ_DEGREE = 3'd2,
        REQ_PATH   = 3'd3,
        REQ_DFS    = 3'd4
    } t_req_e;

endpackage

@@ src/gmd_req_if.sv @@
`timescale 1ns / 1ps

// request channel
interface gmd_req_if import gmd_pkg::*; ;
    logic                     valid;
    logic                     ready;
    logic [REQ_TYPE_W-1:0]    req_type;
    logic [NODE_W-1:0]        node_a;
    logic [NODE_W-1:0]        node_b;
    logic [EDGE_WEIGHT_W-1:0] edge_weight;

    modport source (output valid, req_type, node_a, node_b, edge_weight, input ready);
    modport sink   (input valid, req_type, node_a, node_b, edge_weight, output ready);
endinterface

@@ src/gmd_res_if.sv @@
`timescale 1ns / 1ps

// result channel
interface gmd_res_if import gmd_pkg::*; ;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               status;
    logic               last;

    modport source (output valid, value, status, last, input ready);
    modport sink   (input valid, value, status, last, output ready);
endinterface

@@ src/graph_matrix_dfs_engine.sv @@
// Undirected weighted graph engine over a NODES x NODES adjacency memory (one read and
// one write port, registered read) and a node stack memory, driven by one small sequencer.
// One request item is taken at a time; i_req.ready is low while it is worked on. After
// reset a clearing pass writes zero to all NODES*NODES matrix entries, one per cycle,
// before the first item is taken. A degree query scans one row of size entries, where
// size is num_nodes capped at NODES. Path test and depth-first traversal scan one row
// per reached node and also pop a stack entry for each node already visited; the
// per-row scan of the adjacency memory sets their cost. Each traversal result leaves
// through a single output register, so a stalled result channel stalls the walk.
// Configuration (num_nodes) may be written only while no item is in flight.
`timescale 1ns / 1ps
`include "graph_matrix_dfs_engine_assert.svh"

module graph_matrix_dfs_engine import gmd_pkg::*; #(
    parameter int NODES       = DEF_NODES,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [NUM_NODES_W-1:0] i_cfg_wdata,
    gmd_req_if.sink                i_req,
    gmd_res_if.source              o_res
);

    localparam int NW        = $clog2(NODES);
    localparam int ADJ_DEPTH = NODES * NODES;
    localparam int AW        = $clog2(ADJ_DEPTH);
    localparam int STK_DEPTH = NODES * NODES;
    localparam int SIW       = $clog2(STK_DEPTH);
    localparam int SPW       = $clog2(STK_DEPTH + 1);
    localparam int CW        = $clog2(NODES + 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD2,
        S_EDGE,
        S_SCAN,
        S_POP,
        S_VISIT,
        S_EMIT
    } t_state_e;

    // memories
    logic [WEIGHT_BITS-1:0] r_adj_mem [ADJ_DEPTH];
    logic [WEIGHT_BITS-1:0] r_adj_q;
    logic [NW-1:0]          r_stk_mem [STK_DEPTH];
    logic [NW-1:0]          r_stk_q;

    // sequencer state
    t_state_e               r_state;
    logic [AW-1:0]          r_clr_addr;
    logic [NUM_NODES_W-1:0] r_num_nodes;
    logic [NW-1:0]          r_node_a;
    logic [NW-1:0]          r_node_b;
    logic [WEIGHT_BITS-1:0] r_weight;
    logic                   r_walk;
    logic                   r_path;
    logic [AW-1:0]          r_row_base;
    logic [NW-1:0]          r_scan_idx;
    logic                   r_scan_on;
    logic                   r_rd_vld;
    logic [NW-1:0]          r_rd_idx;
    logic [CW-1:0]          r_deg;
    logic [NODES-1:0]       r_visited;
    logic [SPW-1:0]         r_sp;
    logic [CNT_W-1:0]       r_cnt;
    logic [NW-1:0]          r_pend;
    logic [VALUE_W-1:0]     r_res_value;
    logic                   r_res_status;
    logic                   r_out_valid;
    logic [VALUE_W-1:0]     r_out_value;
    logic                   r_out_status;
    logic                   r_out_last;

    // combinational helpers
    logic [NUM_NODES_W-1:0] size;
    logic [NW-1:0]          size_m1;
    logic [NW-1:0]          in_a;
    logic [NW-1:0]          in_b;
    logic                   a_ok;
    logic                   b_ok;
    logic                   walk_ok;
    logic                   req_ok;
    logic                   req_acc;
    logic [AW-1:0]          in_row_a;
    logic [AW-1:0]          stk_row;
    logic [AW-1:0]          add2_addr;
    logic                   out_free;
    logic                   out_load;
    logic                   nz;
    logic                   push;
    logic [SPW-1:0]         sp_after;
    logic [SPW-1:0]         sp_dec;
    logic                   need_emit;
    logic [VALUE_W-1:0]     fin_value;
    logic                   adj_we;
    logic [AW-1:0]          adj_waddr;
    logic [WEIGHT_BITS-1:0] adj_wdata;
    logic [AW-1:0]          adj_raddr;
    logic                   stk_we;
    logic [SIW-1:0]         stk_waddr;
    logic [NW-1:0]          stk_wdata;
    logic                   stk_re;
    logic [SIW-1:0]         stk_raddr;

    // active node count, capped at NODES
    assign size    = (int'(r_num_nodes) > NODES) ? NUM_NODES_W'(NODES) : r_num_nodes;
    assign size_m1 = NW'(size - 5'd1);

    // request decode
    assign in_a    = NW'(i_req.node_a);
    assign in_b    = NW'(i_req.node_b);
    assign a_ok    = {1'b0, i_req.node_a} < size;
    assign b_ok    = {1'b0, i_req.node_b} < size;
    assign walk_ok = a_ok && (i_req.req_type != REQ_PATH || b_ok);
    assign req_acc = i_req.valid && i_req.ready;

    // known request with every node it uses in range
    always_comb begin
        unique case (i_req.req_type)
            REQ_ADD, REQ_EDGE, REQ_PATH: req_ok = a_ok && b_ok;
            REQ_DEGREE, REQ_DFS:         req_ok = a_ok;
            default:                     req_ok = 1'b0;
        endcase
    end

    // row addresses
    assign in_row_a  = AW'(in_a) * AW'(NODES);
    assign stk_row   = AW'(r_stk_q) * AW'(NODES);
    assign add2_addr = AW'(r_node_b) * AW'(NODES) + AW'(r_node_a);

    // scan and stack bookkeeping
    assign out_free  = !r_out_valid || o_res.ready;
    assign nz        = |r_adj_q;
    assign push      = (r_state == S_SCAN) && r_rd_vld && r_walk && nz
                       && !r_visited[r_rd_idx] && (r_sp != SPW'(STK_DEPTH));
    assign sp_after  = r_sp + SPW'(push);
    assign sp_dec    = r_sp - SPW'(1);
    assign need_emit = !r_path && (r_cnt != '0) && (r_cnt < CNT_W'(OUT_CAP));
    assign fin_value = r_path ? VALUE_W'(r_visited[r_node_b]) : VALUE_W'(r_pend);

    // output register takes a new result
    assign out_load  = ((r_state == S_EMIT) && out_free)
                       || ((r_state == S_VISIT) && !r_visited[r_stk_q] && need_emit
                           && out_free);

    // memory port control
    always_comb begin
        adj_we    = 1'b0;
        adj_waddr = r_clr_addr;
        adj_wdata = '0;
        adj_raddr = in_row_a + AW'(in_b);
        stk_we    = 1'b0;
        stk_waddr = r_sp[SIW-1:0];
        stk_wdata = r_rd_idx;
        stk_re    = 1'b0;
        stk_raddr = sp_dec[SIW-1:0];
        unique case (r_state)
            S_CLEAR: begin
                adj_we = 1'b1;
            end
            S_IDLE: begin
                if (req_acc && i_req.req_type == REQ_ADD && a_ok && b_ok) begin
                    adj_we    = 1'b1;
                    adj_waddr = in_row_a + AW'(in_b);
                    adj_wdata = WEIGHT_BITS'(i_req.edge_weight);
                end
                if (req_acc && walk_ok
                    && (i_req.req_type == REQ_PATH || i_req.req_type == REQ_DFS)) begin
                    stk_we    = 1'b1;
                    stk_waddr = '0;
                    stk_wdata = in_a;
                end
            end
            S_ADD2: begin
                adj_we    = 1'b1;
                adj_waddr = add2_addr;
                adj_wdata = r_weight;
            end
            S_SCAN: begin
                adj_raddr = r_row_base + AW'(r_scan_idx);
                stk_we    = push;
            end
            S_POP: begin
                stk_re = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // adjacency memory
    always_ff @(posedge i_clk) begin
        if (adj_we) begin
            r_adj_mem[adj_waddr] <= adj_wdata;
        end
        r_adj_q <= r_adj_mem[adj_raddr];
    end

    // node stack memory
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re) begin
            r_stk_q <= r_stk_mem[stk_raddr];
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_nodes <= NUM_NODES_RESET;
        end else if (i_cfg_we) begin
            r_num_nodes <= i_cfg_wdata;
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_scan_on   <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_visited   <= '0;
            r_sp        <= '0;
            r_cnt       <= '0;
            r_walk      <= 1'b0;
            r_path      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                // zero the matrix once after reset
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(ADJ_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                // take a request and dispatch it
                S_IDLE: begin
                    if (req_acc) begin
                        r_node_a     <= in_a;
                        r_node_b     <= in_b;
                        r_weight     <= WEIGHT_BITS'(i_req.edge_weight);
                        r_path       <= (i_req.req_type == REQ_PATH);
                        r_res_value  <= '0;
                        r_res_status <= !req_ok;
                        unique case (i_req.req_type)
                            REQ_ADD: begin
                                if (a_ok && b_ok) begin
                                    r_state <= S_ADD2;
                                end else begin
                                    r_state <= S_EMIT;
                                end
                            end
                            REQ_EDGE: begin
                                if (a_ok && b_ok) begin
                                    r_state <= S_EDGE;
                                end else begin
                                    r_state <= S_EMIT;
                                end
                            end
                            REQ_DEGREE: begin
                                if (a_ok) begin
                                    r_walk     <= 1'b0;
                                    r_deg      <= '0;
                                    r_row_base <= in_row_a;
                                    r_scan_idx <= size_m1;
                                    r_scan_on  <= 1'b1;
                                    r_state    <= S_SCAN;
                                end else begin
                                    r_state <= S_EMIT;
                                end
                            end
                            REQ_PATH, REQ_DFS: begin
                                if (walk_ok) begin
                                    r_walk    <= 1'b1;
                                    r_visited <= '0;
                                    r_sp      <= SPW'(1);
                                    r_cnt     <= '0;
                                    r_state   <= S_POP;
                                end else begin
                                    r_state <= S_EMIT;
                                end
                            end
                            default: begin
                                r_state <= S_EMIT;
                            end
                        endcase
                    end
                end
                // mirror write of an added edge
                S_ADD2: begin
                    r_state <= S_EMIT;
                end
                // edge weight read is back
                S_EDGE: begin
                    r_res_value <= VALUE_W'(nz);
                    r_state     <= S_EMIT;
                end
                // stream one row, high node first
                S_SCAN: begin
                    if (r_scan_on) begin
                        r_rd_vld <= 1'b1;
                        r_rd_idx <= r_scan_idx;
                        if (r_scan_idx == '0) begin
                            r_scan_on <= 1'b0;
                        end else begin
                            r_scan_idx <= r_scan_idx - NW'(1);
                        end
                    end else begin
                        r_rd_vld <= 1'b0;
                    end
                    if (r_rd_vld) begin
                        r_sp <= sp_after;
                        if (nz) begin
                            r_deg <= r_deg + CW'(1);
                        end
                        if (r_rd_idx == '0) begin
                            if (!r_walk) begin
                                r_res_value <= VALUE_W'(r_deg + CW'(nz));
                                r_state     <= S_EMIT;
                            end else if (sp_after != '0) begin
                                r_state <= S_POP;
                            end else begin
                                r_res_value <= fin_value;
                                r_state     <= S_EMIT;
                            end
                        end
                    end
                end
                // pop the top of the stack
                S_POP: begin
                    r_sp    <= sp_dec;
                    r_state <= S_VISIT;
                end
                // visit the popped node unless already seen
                S_VISIT: begin
                    if (r_visited[r_stk_q]) begin
                        if (r_sp == '0) begin
                            r_res_value <= fin_value;
                            r_state     <= S_EMIT;
                        end else begin
                            r_state <= S_POP;
                        end
                    end else if (!need_emit || out_free) begin
                        if (need_emit) begin
                            r_out_value  <= VALUE_W'(r_pend);
                            r_out_status <= 1'b0;
                            r_out_last   <= 1'b0;
                        end
                        if (r_cnt < CNT_W'(OUT_CAP)) begin
                            r_pend <= r_stk_q;
                            r_cnt  <= r_cnt + CNT_W'(1);
                        end
                        r_visited[r_stk_q] <= 1'b1;
                        r_row_base         <= stk_row;
                        r_scan_idx         <= size_m1;
                        r_scan_on          <= 1'b1;
                        r_state            <= S_SCAN;
                    end
                end
                // final result of the item
                S_EMIT: begin
                    if (out_free) begin
                        r_out_value  <= r_res_value;
                        r_out_status <= r_res_status;
                        r_out_last   <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // channel hookup
    assign i_req.ready  = (r_state == S_IDLE);
    assign o_res.valid  = r_out_valid;
    assign o_res.value  = r_out_value;
    assign o_res.status = r_out_status;
    assign o_res.last   = r_out_last;

    // checks
    `GMD_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, req_acc, r_state != S_IDLE,
                     "item accepted but sequencer stayed idle")
    `GMD_ASSERT_NOW(a_pop_nonempty, i_clk, i_rst_n, r_state == S_POP, r_sp != '0,
                    "pop from an empty stack")
    `GMD_ASSERT_NOW(a_scan_in_range, i_clk, i_rst_n, r_rd_vld, int'(r_rd_idx) < int'(size),
                    "row scan beyond active node count")
    `GMD_ASSERT_NEXT(a_emit_needs_room, i_clk, i_rst_n, r_state == S_EMIT && !out_free,
                     r_state == S_EMIT, "result dropped while output busy")

endmodule
